>>> hw/rtl/rau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int RES_WIDTH         = 32;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

endpackage : rau_pkg
`default_nettype wire

>>> hw/rtl/rau_reduce.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rau_reduce
// Reduces one fraction n/d by gcd(|n|,|d|); a zero part leaves it as it is.
// Binary gcd followed by two restoring divisions, all on one shared subtractor.
// ----------------------------------------------------------------------------
module rau_reduce
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic signed [OPERAND_WIDTH-1:0] num_in,
    input  wire logic signed [OPERAND_WIDTH-1:0] den_in,
    output      logic                            done,
    output      logic signed [OPERAND_WIDTH-1:0] num_red,
    output      logic signed [OPERAND_WIDTH-1:0] den_red
);

    localparam int W  = OPERAND_WIDTH;
    localparam int KW = $clog2(W);

    typedef enum logic [4:0] {
        R_IDLE = 5'b00001,
        R_GCD  = 5'b00010,
        R_DIVN = 5'b00100,
        R_DIVD = 5'b01000,
        R_DONE = 5'b10000
    } red_state_t;

    red_state_t state_reg, state_next;

    logic [W-1:0]  mn_reg, mn_next;
    logic [W-1:0]  md_reg, md_next;
    logic          neg_n_reg, neg_n_next;
    logic          neg_d_reg, neg_d_next;
    logic [W-1:0]  u_reg, u_next;
    logic [W-1:0]  v_reg, v_next;
    logic [KW-1:0] k_reg, k_next;
    logic [W-1:0]  g_reg, g_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [KW-1:0] cnt_reg, cnt_next;
    logic signed [W-1:0] num_red_reg, num_red_next;
    logic signed [W-1:0] den_red_reg, den_red_next;

    logic [W-1:0] mag_n, mag_d;
    logic [W:0]   rem_sh;
    logic [W:0]   sub_a, sub_b, diff;
    logic [W-1:0] neg_diff;
    logic [W-1:0] quo_step, rem_step;
    logic [W-1:0] quo_signed;

    assign mag_n = num_in[W-1] ? W'(~num_in + 1'b1) : W'(num_in);
    assign mag_d = den_in[W-1] ? W'(~den_in + 1'b1) : W'(den_in);

    assign rem_sh = {rem_reg, quo_reg[W-1]};

    // the one subtractor: u - v during gcd, trial subtract during divide
    always_comb
    begin
        case (state_reg)
            R_GCD:
            begin
                sub_a = {1'b0, u_reg};
                sub_b = {1'b0, v_reg};
            end
            default:
            begin
                sub_a = rem_sh;
                sub_b = {1'b0, g_reg};
            end
        endcase
    end

    assign diff     = sub_a - sub_b;
    assign neg_diff = ~diff[W-1:0] + 1'b1;
    assign quo_step = {quo_reg[W-2:0], ~diff[W]};
    assign rem_step = diff[W] ? rem_sh[W-1:0] : diff[W-1:0];

    always_comb
    begin
        quo_signed = (state_reg == R_DIVN ? neg_n_reg : neg_d_reg)
                     ? W'(~quo_step + 1'b1) : quo_step;
    end

    always_comb
    begin
        state_next   = state_reg;
        mn_next      = mn_reg;
        md_next      = md_reg;
        neg_n_next   = neg_n_reg;
        neg_d_next   = neg_d_reg;
        u_next       = u_reg;
        v_next       = v_reg;
        k_next       = k_reg;
        g_next       = g_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        num_red_next = num_red_reg;
        den_red_next = den_red_reg;

        case (state_reg)
            R_IDLE:
            begin
                if (start)
                begin
                    mn_next    = mag_n;
                    md_next    = mag_d;
                    neg_n_next = num_in[W-1];
                    neg_d_next = den_in[W-1];
                    u_next     = mag_n;
                    v_next     = mag_d;
                    k_next     = '0;
                    if (mag_n == '0 || mag_d == '0)
                    begin
                        // zero part: left unreduced
                        num_red_next = num_in;
                        den_red_next = den_in;
                        state_next   = R_DONE;
                    end
                    else
                    begin
                        state_next = R_GCD;
                    end
                end
            end

            R_GCD:
            begin
                if (u_reg == v_reg)
                begin
                    g_next     = u_reg << k_reg;
                    rem_next   = '0;
                    quo_next   = mn_reg;
                    cnt_next   = '0;
                    state_next = R_DIVN;
                end
                else if (!u_reg[0] && !v_reg[0])
                begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
                else if (!u_reg[0])
                begin
                    u_next = u_reg >> 1;
                end
                else if (!v_reg[0])
                begin
                    v_next = v_reg >> 1;
                end
                else if (!diff[W])
                begin
                    u_next = diff[W-1:0] >> 1;
                end
                else
                begin
                    v_next = neg_diff >> 1;
                end
            end

            R_DIVN:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == KW'(W - 1))
                begin
                    num_red_next = quo_signed;
                    rem_next     = '0;
                    quo_next     = md_reg;
                    cnt_next     = '0;
                    state_next   = R_DIVD;
                end
            end

            R_DIVD:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == KW'(W - 1))
                begin
                    den_red_next = quo_signed;
                    state_next   = R_DONE;
                end
            end

            R_DONE:
            begin
                state_next = R_IDLE;
            end

            default:
            begin
                state_next = R_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mn_reg      <= mn_next;
        md_reg      <= md_next;
        neg_n_reg   <= neg_n_next;
        neg_d_reg   <= neg_d_next;
        u_reg       <= u_next;
        v_reg       <= v_next;
        k_reg       <= k_next;
        g_reg       <= g_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        cnt_reg     <= cnt_next;
        num_red_reg <= num_red_next;
        den_red_reg <= den_red_next;
    end

    assign done    = (state_reg == R_DONE);
    assign num_red = num_red_reg;
    assign den_red = den_red_reg;

endmodule : rau_reduce
`default_nettype wire

>>> hw/rtl/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Reduces two signed fractions by their gcds, then adds, subtracts,
// multiplies or divides them with 32-bit wrapping results.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------
//  in       | in_valid / in_ready  | cmd, num_a, den_a, num_b, den_b
//  out      | out_valid / out_ready| num_out, den_out, den_is_zero
//
//  Each operand passes through the reducer: a load state, binary gcd
//  steps until u and v match, a restoring division of each part and a done
//  state; a zero part goes straight to done. The single 32x32 multiplier
//  then forms three products in turn, and the result stage loads the output
//  register once it is free. in_ready is high only while the sequencer
//  idles; a finished result sits in the output register while the next
//  request is taken. Reset clears control state only.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output      logic                            in_ready,
    input  wire logic [1:0]                      cmd,
    input  wire logic signed [OPERAND_WIDTH-1:0] num_a,
    input  wire logic signed [OPERAND_WIDTH-1:0] den_a,
    input  wire logic signed [OPERAND_WIDTH-1:0] num_b,
    input  wire logic signed [OPERAND_WIDTH-1:0] den_b,
    output      logic                            out_valid,
    input  wire logic                            out_ready,
    output      logic signed [RES_WIDTH-1:0]     num_out,
    output      logic signed [RES_WIDTH-1:0]     den_out,
    output      logic                            den_is_zero
);

    localparam int W = OPERAND_WIDTH;
    localparam int R = RES_WIDTH;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_LOAD_A = 7'b0000010,
        S_RED_A  = 7'b0000100,
        S_LOAD_B = 7'b0001000,
        S_RED_B  = 7'b0010000,
        S_MUL    = 7'b0100000,
        S_FIN    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    cmd_t                cmd_reg, cmd_next;
    logic signed [W-1:0] na_reg, na_next;
    logic signed [W-1:0] da_reg, da_next;
    logic signed [W-1:0] nb_reg, nb_next;
    logic signed [W-1:0] db_reg, db_next;
    logic [R-1:0]        n1_reg, n1_next;
    logic [R-1:0]        d1_reg, d1_next;
    logic [R-1:0]        n2_reg, n2_next;
    logic [R-1:0]        d2_reg, d2_next;
    logic [R-1:0]        p0_reg, p0_next;
    logic [R-1:0]        p1_reg, p1_next;
    logic [R-1:0]        p2_reg, p2_next;
    logic [1:0]          mstep_reg, mstep_next;

    logic                out_valid_reg, out_valid_next;
    logic [R-1:0]        num_out_reg, num_out_next;
    logic [R-1:0]        den_out_reg, den_out_next;
    logic                dz_reg, dz_next;

    logic                red_start, red_done;
    logic signed [W-1:0] red_num_in, red_den_in;
    logic signed [W-1:0] red_num, red_den;

    logic [R-1:0]        mul_a, mul_b, product;
    logic [R-1:0]        rn, rd;
    logic                in_fire, out_free;

    rau_reduce #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_reduce (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (red_start),
        .num_in  (red_num_in),
        .den_in  (red_den_in),
        .done    (red_done),
        .num_red (red_num),
        .den_red (red_den)
    );

    assign red_start  = (state_reg == S_LOAD_A) || (state_reg == S_LOAD_B);
    assign red_num_in = (state_reg == S_LOAD_A) ? na_reg : nb_reg;
    assign red_den_in = (state_reg == S_LOAD_A) ? da_reg : db_reg;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // shared multiplier, low 32 bits only
    always_comb
    begin
        case (mstep_reg)
            2'd0:
            begin
                mul_a = n1_reg;
                mul_b = (cmd_reg == CMD_MUL) ? n2_reg : d2_reg;
            end
            2'd1:
            begin
                mul_a = d1_reg;
                mul_b = (cmd_reg == CMD_MUL) ? d2_reg : n2_reg;
            end
            default:
            begin
                mul_a = d1_reg;
                mul_b = d2_reg;
            end
        endcase
    end

    assign product = mul_a * mul_b;

    always_comb
    begin
        case (cmd_reg)
            CMD_ADD:
            begin
                if (d1_reg == d2_reg)
                begin
                    rn = n1_reg + n2_reg;
                    rd = d1_reg;
                end
                else
                begin
                    rn = p0_reg + p1_reg;
                    rd = p2_reg;
                end
            end
            CMD_SUB:
            begin
                if (n1_reg == n2_reg && d1_reg == d2_reg)
                begin
                    rn = '0;
                    rd = R'(1);
                end
                else if (d1_reg == d2_reg)
                begin
                    rn = n1_reg - n2_reg;
                    rd = d1_reg;
                end
                else
                begin
                    rn = p0_reg - p1_reg;
                    rd = p2_reg;
                end
            end
            default:
            begin
                // multiply and divide: operands were picked in the multiplier
                rn = p0_reg;
                rd = p1_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        na_next        = na_reg;
        da_next        = da_reg;
        nb_next        = nb_reg;
        db_next        = db_reg;
        n1_next        = n1_reg;
        d1_next        = d1_reg;
        n2_next        = n2_reg;
        d2_next        = d2_reg;
        p0_next        = p0_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        mstep_next     = mstep_reg;
        out_valid_next = out_valid_reg;
        num_out_next   = num_out_reg;
        den_out_next   = den_out_reg;
        dz_next        = dz_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next   = cmd_t'(cmd);
                    na_next    = num_a;
                    da_next    = den_a;
                    nb_next    = num_b;
                    db_next    = den_b;
                    state_next = S_LOAD_A;
                end
            end
            S_LOAD_A:
            begin
                state_next = S_RED_A;
            end
            S_RED_A:
            begin
                if (red_done)
                begin
                    n1_next    = R'(red_num);
                    d1_next    = R'(red_den);
                    state_next = S_LOAD_B;
                end
            end
            S_LOAD_B:
            begin
                state_next = S_RED_B;
            end
            S_RED_B:
            begin
                if (red_done)
                begin
                    n2_next    = R'(red_num);
                    d2_next    = R'(red_den);
                    mstep_next = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                mstep_next = mstep_reg + 1'b1;
                case (mstep_reg)
                    2'd0:    p0_next = product;
                    2'd1:    p1_next = product;
                    default:
                    begin
                        p2_next    = product;
                        state_next = S_FIN;
                    end
                endcase
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    num_out_next   = rn;
                    den_out_next   = rd;
                    dz_next        = (rd == '0);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        na_reg      <= na_next;
        da_reg      <= da_next;
        nb_reg      <= nb_next;
        db_reg      <= db_next;
        n1_reg      <= n1_next;
        d1_reg      <= d1_next;
        n2_reg      <= n2_next;
        d2_reg      <= d2_next;
        p0_reg      <= p0_next;
        p1_reg      <= p1_next;
        p2_reg      <= p2_next;
        mstep_reg   <= mstep_next;
        num_out_reg <= num_out_next;
        den_out_reg <= den_out_next;
        dz_reg      <= dz_next;
    end

    assign out_valid   = out_valid_reg;
    assign num_out     = num_out_reg;
    assign den_out     = den_out_reg;
    assign den_is_zero = dz_reg;

endmodule : rational_arithmetic_unit
`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the rational arithmetic unit with fraction pairs under random
// source and sink stalls. Each request is predicted (per-operand gcd
// reduction, then 32-bit wrapping add/sub/mul/div) and every result is
// checked in order against the prediction.
// ----------------------------------------------------------------------------
module testbench;
    import rau_pkg::*;

    localparam int W            = OPERAND_WIDTH_DEF;
    localparam int RANDOM_ITEMS = 1850;
    localparam int LIMIT        = 2_500_000;
    localparam int DRAIN        = 200;

    typedef struct packed {
        logic signed [RES_WIDTH-1:0] num;
        logic signed [RES_WIDTH-1:0] den;
        logic                        den_zero;
    } fraction_t;

    class fraction_checker;
        fraction_t pending_fractions[$];
        int        failures = 0;

        function void reduce_part(input logic signed [W-1:0] n, input logic signed [W-1:0] d,
                                  output logic [31:0] rn, output logic [31:0] rd);
            longint          sn, sd, g;
            longint unsigned x, y, t;
            sn = n;
            sd = d;
            x  = (sn < 0) ? -sn : sn;
            y  = (sd < 0) ? -sd : sd;
            // a zero part leaves the operand as it is
            if (x != 0 && y != 0)
            begin
                while (y != 0)
                begin
                    t = x % y;
                    x = y;
                    y = t;
                end
                g  = x;
                sn = sn / g;
                sd = sd / g;
            end
            rn = sn[31:0];
            rd = sd[31:0];
        endfunction

        function void note_request(input cmd_t op,
                                   input logic signed [W-1:0] na, input logic signed [W-1:0] da,
                                   input logic signed [W-1:0] nb, input logic signed [W-1:0] db);
            logic [31:0] n1, d1, n2, d2, rn, rd;
            fraction_t   f;
            reduce_part(na, da, n1, d1);
            reduce_part(nb, db, n2, d2);
            case (op)
                CMD_ADD:
                begin
                    if (d1 == d2)
                    begin
                        rn = n1 + n2;
                        rd = d1;
                    end
                    else
                    begin
                        rn = n1 * d2 + d1 * n2;
                        rd = d1 * d2;
                    end
                end
                CMD_SUB:
                begin
                    // identical reduced operands give 0/1
                    if (n1 == n2 && d1 == d2)
                    begin
                        rn = 32'd0;
                        rd = 32'd1;
                    end
                    else if (d1 == d2)
                    begin
                        rn = n1 - n2;
                        rd = d1;
                    end
                    else
                    begin
                        rn = n1 * d2 - d1 * n2;
                        rd = d1 * d2;
                    end
                end
                CMD_MUL:
                begin
                    rn = n1 * n2;
                    rd = d1 * d2;
                end
                default:
                begin
                    rn = n1 * d2;
                    rd = d1 * n2;
                end
            endcase
            f.num      = rn;
            f.den      = rd;
            f.den_zero = (rd == 32'd0);
            pending_fractions.push_back(f);
        endfunction

        function void check_result(input logic signed [RES_WIDTH-1:0] num,
                                   input logic signed [RES_WIDTH-1:0] den,
                                   input logic zero);
            fraction_t f;
            if (pending_fractions.size() == 0)
            begin
                $error("unexpected result: num_out=%0d den_out=%0d den_is_zero=%0b",
                       num, den, zero);
                failures++;
                return;
            end
            f = pending_fractions.pop_front();
            if (num !== f.num)
            begin
                $error("num_out: expected %0d, got %0d", f.num, num);
                failures++;
            end
            if (den !== f.den)
            begin
                $error("den_out: expected %0d, got %0d", f.den, den);
                failures++;
            end
            if (zero !== f.den_zero)
            begin
                $error("den_is_zero: expected %0b, got %0b", f.den_zero, zero);
                failures++;
            end
        endfunction

        function int pending();
            return pending_fractions.size();
        endfunction
    endclass

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        in_valid  = 1'b0;
    logic                        in_ready;
    logic [1:0]                  cmd       = '0;
    logic signed [W-1:0]         num_a     = '0;
    logic signed [W-1:0]         den_a     = '0;
    logic signed [W-1:0]         num_b     = '0;
    logic signed [W-1:0]         den_b     = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic signed [RES_WIDTH-1:0] num_out;
    logic signed [RES_WIDTH-1:0] den_out;
    logic                        den_is_zero;

    fraction_checker board = new();
    logic            quiet = 1'b1;
    int              stall_left = 0;
    int unsigned     cycle_count = 0;

    rational_arithmetic_unit #(
        .OPERAND_WIDTH(W)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .num_a      (num_a),
        .den_a      (den_a),
        .num_b      (num_b),
        .den_b      (den_b),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .num_out    (num_out),
        .den_out    (den_out),
        .den_is_zero(den_is_zero)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    function automatic int rand_span(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic logic signed [W-1:0] rand_extreme();
        case ($urandom_range(0, 6))
            0: return W'(-32768);
            1: return W'(-32767);
            2: return W'(-1);
            3: return W'(0);
            4: return W'(1);
            5: return W'(32767);
            default: return W'($urandom);
        endcase
    endfunction

    task automatic send_request(input cmd_t op,
                                input logic signed [W-1:0] na, input logic signed [W-1:0] da,
                                input logic signed [W-1:0] nb, input logic signed [W-1:0] db);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        num_a    <= na;
        den_a    <= da;
        num_b    <= nb;
        den_b    <= db;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_request(op, na, da, nb, db);
    endtask

    // result sink with random backpressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check_result(num_out, den_out, den_is_zero);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        wait (cycle_count >= LIMIT);
        $display("[rational_arithmetic_unit] ERROR");
        $finish;
    end

    initial
    begin
        int                  kind, k, pa, qa;
        cmd_t                op;
        logic signed [W-1:0] na, da, nb, db;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        send_request(CMD_ADD, 1, 2, 1, 3);
        send_request(CMD_ADD, 1, 4, 3, 4);
        send_request(CMD_ADD, 2, 4, 3, 6);
        send_request(CMD_SUB, 3, 6, 1, 2);
        send_request(CMD_SUB, 0, 0, 0, 0);
        send_request(CMD_SUB, 5, 7, 2, 7);
        send_request(CMD_SUB, 1, 3, 1, 5);
        send_request(CMD_MUL, -6, 4, 10, -15);
        send_request(CMD_DIV, 3, 4, 0, 5);
        send_request(CMD_ADD, 7, 0, 1, 2);
        send_request(CMD_MUL, 0, 9, 4, 6);
        send_request(CMD_DIV, -32768, -32768, 32767, -32768);
        send_request(CMD_ADD, -32768, 32767, 32767, -32768);
        send_request(CMD_SUB, -32768, -32767, 32767, 32767);
        send_request(CMD_MUL, -32768, -1, -32768, -1);
        send_request(CMD_DIV, 32767, -32768, -32768, 32767);
        send_request(CMD_ADD, 0, 0, 0, 0);
        send_request(CMD_SUB, 32767, 32765, -32768, 32767);
        send_request(CMD_MUL, 12, -18, -7, 0);
        send_request(CMD_DIV, -1, 1, 1, -1);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            quiet = ((i / 150) % 3 == 0);
            op    = cmd_t'($urandom_range(0, 3));
            kind  = $urandom_range(0, 9);
            case (kind)
                0, 1, 2:
                begin
                    na = W'($urandom);
                    da = W'($urandom);
                    nb = W'($urandom);
                    db = W'($urandom);
                end
                3, 4:
                begin
                    na = W'(rand_span(20));
                    da = W'(rand_span(20));
                    nb = W'(rand_span(20));
                    db = W'(rand_span(20));
                end
                5:
                begin
                    // shared denominator
                    na = W'(rand_span(300));
                    nb = W'(rand_span(300));
                    da = W'(rand_span(300));
                    db = da;
                end
                6:
                begin
                    // same fraction scaled, mostly subtracted
                    pa = rand_span(150);
                    qa = rand_span(150);
                    k  = rand_span(60);
                    na = W'(pa);
                    da = W'(qa);
                    nb = W'(pa * k);
                    db = W'(qa * k);
                    if ($urandom_range(0, 1) == 0)
                        op = CMD_SUB;
                end
                7:
                begin
                    na = W'($urandom);
                    da = W'($urandom);
                    nb = W'($urandom);
                    db = W'($urandom);
                    case ($urandom_range(0, 3))
                        0: na = '0;
                        1: da = '0;
                        2: nb = '0;
                        default: db = '0;
                    endcase
                end
                8:
                begin
                    na = rand_extreme();
                    da = rand_extreme();
                    nb = rand_extreme();
                    db = rand_extreme();
                end
                default:
                begin
                    na = W'(rand_span(2000));
                    da = W'(rand_span(2000));
                    nb = W'(rand_span(2000));
                    db = W'(rand_span(2000));
                end
            endcase
            send_request(op, na, da, nb, db);
        end
        in_valid <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (board.failures == 0)
            $display("[rational_arithmetic_unit] OK");
        else
            $display("[rational_arithmetic_unit] ERROR");
        $finish;
    end

endmodule
